### hw/rtl/lpkv_pkg.sv
// lpkv_pkg: types, constants and helpers for the linear probe key value table
// used by lpkv_front, lpkv_fifo, lpkv_back and the top level
`timescale 1ns / 1ps
`default_nettype none
package lpkv_pkg;

  localparam int CAPACITY_DEF  = 256;
  localparam int KEY_BYTES_DEF = 15;
  localparam int KEY_LEN_W     = 4;
  localparam int MAXE_W        = 9;
  localparam logic [MAXE_W-1:0] MAXE_RESET = 9'd179;
  localparam int FIFO_DEPTH    = 2;

  localparam logic [1:0] KIND_PUT    = 2'd0;
  localparam logic [1:0] KIND_GET    = 2'd1;
  localparam logic [1:0] KIND_RANK   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key_lo;
    logic [55:0] key_hi;
    logic [3:0]  key_len;
    logic signed [31:0] put_value;
    logic [7:0]  slot_rank;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic signed [31:0] found_value;
    logic [63:0] out_key_lo;
    logic [55:0] out_key_hi;
    logic [3:0]  out_key_len;
    logic [8:0]  entry_count;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key_lo;
    logic [55:0] key_hi;
    logic [3:0]  key_len;
    logic [31:0] value;
    logic [7:0]  rank;
    logic [31:0] hash;
  } cmd_t;

endpackage
`default_nettype wire

### hw/rtl/lpkv_front.sv
// lpkv_front: accepts transactions, canonicalizes the key and hashes it one
// byte per cycle; depends on lpkv_pkg
`timescale 1ns / 1ps
`default_nettype none
module lpkv_front #(
  parameter int KEY_BYTES = lpkv_pkg::KEY_BYTES_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  lpkv_pkg::in_item_t  in_data,
  output logic                cmd_valid,
  input  wire                 cmd_ready,
  output lpkv_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_HASH = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t        state_r, state_nxt;
  lpkv_pkg::cmd_t cmd_r, cmd_nxt;
  logic [3:0]     idx_r, idx_nxt;
  logic [119:0]   key_all;
  logic [119:0]   mask;
  logic [3:0]     len_sat;
  logic [7:0]     cur_byte;
  logic [119:0]   kcat;

  assign in_ready  = (state_r == F_IDLE);
  assign cmd_valid = (state_r == F_PUSH);
  assign cmd       = cmd_r;
  assign kcat      = {cmd_r.key_hi, cmd_r.key_lo};
  assign cur_byte  = kcat[{idx_r, 3'b000} +: 8];

  always_comb begin
    len_sat = (in_data.key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_data.key_len;
    key_all = {in_data.key_hi, in_data.key_lo};
    mask    = 120'd0;
    for (int i = 0; i < 15; i++) begin
      if (4'(i) < len_sat) mask[8*i +: 8] = 8'hff;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          cmd_nxt.kind    = in_data.kind;
          cmd_nxt.key_lo  = key_all[63:0] & mask[63:0];
          cmd_nxt.key_hi  = key_all[119:64] & mask[119:64];
          cmd_nxt.key_len = len_sat;
          cmd_nxt.value   = in_data.put_value;
          cmd_nxt.rank    = in_data.slot_rank;
          cmd_nxt.hash    = 32'd0;
          idx_nxt         = 4'd0;
          state_nxt       = F_HASH;
        end
      end
      F_HASH: begin
        if (idx_r >= cmd_r.key_len) begin
          state_nxt = F_PUSH;
        end else begin
          cmd_nxt.hash = (cmd_r.hash << 5) + cmd_r.hash + {24'd0, cur_byte};
          idx_nxt      = idx_r + 4'd1;
        end
      end
      F_PUSH: begin
        if (cmd_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/lpkv_fifo.sv
// lpkv_fifo: short command queue between front and back
// depends on lpkv_pkg
`timescale 1ns / 1ps
`default_nettype none
module lpkv_fifo (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             wr_valid,
  output logic            wr_ready,
  input  lpkv_pkg::cmd_t  wr_data,
  output logic            rd_valid,
  input  wire             rd_ready,
  output lpkv_pkg::cmd_t  rd_data
);

  localparam int D = lpkv_pkg::FIFO_DEPTH;
  localparam int AW = $clog2(D);

  lpkv_pkg::cmd_t mem_r [D];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           do_wr, do_rd;

  assign wr_ready = (cnt_r != (AW+1)'(D));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + AW'(1);
      if (do_rd) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

### hw/rtl/lpkv_back.sv
// lpkv_back: probes the slot memories, carries out put, get and key-at-index,
// and holds the result register; depends on lpkv_pkg
`timescale 1ns / 1ps
`default_nettype none
module lpkv_back #(
  parameter int CAPACITY = lpkv_pkg::CAPACITY_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire [8:0]           max_entries,
  input  wire                 cmd_valid,
  output logic                cmd_ready,
  input  lpkv_pkg::cmd_t      cmd,
  output logic                out_valid,
  input  wire                 out_ready,
  output lpkv_pkg::out_item_t out_data
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = SW + 1;

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_MOD   = 6'b000010,
    B_READ  = 6'b000100,
    B_CHECK = 6'b001000,
    B_DONE  = 6'b010000,
    B_OUT   = 6'b100000
  } bstate_t;

  bstate_t        state_r, state_nxt;
  lpkv_pkg::cmd_t c_r, c_nxt;
  logic [31:0]    rem_r, rem_nxt;
  logic [2:0]     dig_r, dig_nxt;
  logic [SW-1:0]  slot_r, slot_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic [8:0]     cnt_r, cnt_nxt;
  logic [8:0]     occ_r, occ_nxt;
  logic [CAPACITY-1:0] valid_r;
  lpkv_pkg::out_item_t res_r, res_nxt;

  logic [63:0] klo_mem [CAPACITY];
  logic [55:0] khi_mem [CAPACITY];
  logic [3:0]  klen_mem [CAPACITY];
  logic [31:0] val_mem [CAPACITY];
  logic [63:0] rd_klo;
  logic [55:0] rd_khi;
  logic [3:0]  rd_klen;
  logic [31:0] rd_val;
  logic        rd_vld;

  logic        wr_key, wr_val, set_valid;

  assign cmd_ready = (state_r == B_IDLE);
  assign out_valid = (state_r == B_OUT);
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    rd_klo  <= klo_mem[slot_r];
    rd_khi  <= khi_mem[slot_r];
    rd_klen <= klen_mem[slot_r];
    rd_val  <= val_mem[slot_r];
    rd_vld  <= valid_r[slot_r];
    if (wr_key) begin
      klo_mem[slot_r]  <= c_r.key_lo;
      khi_mem[slot_r]  <= c_r.key_hi;
      klen_mem[slot_r] <= c_r.key_len;
    end
    if (wr_val) val_mem[slot_r] <= c_r.value;
  end

  always_comb begin
    logic hit;
    logic [CW-1:0] pr;
    hit       = rd_vld && (rd_klen == c_r.key_len) && (rd_klo == c_r.key_lo)
                && (rd_khi == c_r.key_hi);
    pr        = '0;
    state_nxt = state_r;
    c_nxt     = c_r;
    rem_nxt   = rem_r;
    dig_nxt   = dig_r;
    slot_nxt  = slot_r;
    n_nxt     = n_r;
    cnt_nxt   = cnt_r;
    occ_nxt   = occ_r;
    res_nxt   = res_r;
    wr_key    = 1'b0;
    wr_val    = 1'b0;
    set_valid = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          c_nxt    = cmd;
          rem_nxt  = cmd.hash;
          dig_nxt  = '0;
          slot_nxt = '0;
          n_nxt    = '0;
          cnt_nxt  = '0;
          res_nxt  = '0;
          res_nxt.status = lpkv_pkg::ST_NOTFOUND;
          if (cmd.kind == lpkv_pkg::KIND_RANK) begin
            state_nxt = B_READ;
          end else if (cmd.kind == lpkv_pkg::KIND_PUT || cmd.kind == lpkv_pkg::KIND_GET) begin
            state_nxt = B_MOD;
          end else begin
            state_nxt = B_DONE;
          end
        end
      end
      // reduce hash modulo capacity: four hash bits per cycle, msb first,
      // running remainder kept in slot_r until all 32 hash bits are taken
      B_MOD: begin
        pr = {1'b0, slot_r};
        for (int k = 0; k < 4; k++) begin
          pr = {pr[SW-1:0], rem_r[31-k]};
          if (pr >= CW'(CAPACITY)) pr = pr - CW'(CAPACITY);
        end
        slot_nxt = pr[SW-1:0];
        rem_nxt  = rem_r << 4;
        dig_nxt  = dig_r + 3'd1;
        if (dig_r == 3'd7) state_nxt = B_READ;
      end
      B_READ: state_nxt = B_CHECK;
      B_CHECK: begin
        if (c_r.kind == lpkv_pkg::KIND_RANK) begin
          if (rd_vld && cnt_r == {1'b0, c_r.rank}) begin
            res_nxt.status      = lpkv_pkg::ST_OK;
            res_nxt.out_key_lo  = rd_klo;
            res_nxt.out_key_hi  = rd_khi;
            res_nxt.out_key_len = rd_klen;
            state_nxt = B_DONE;
          end else begin
            if (rd_vld) cnt_nxt = cnt_r + 9'd1;
            if (slot_r == SW'(CAPACITY - 1)) begin
              state_nxt = B_DONE;
            end else begin
              slot_nxt  = slot_r + SW'(1);
              state_nxt = B_READ;
            end
          end
        end else if (!rd_vld) begin
          if (c_r.kind == lpkv_pkg::KIND_PUT) begin
            if (occ_r >= max_entries) begin
              res_nxt.status = lpkv_pkg::ST_FULL;
            end else begin
              wr_key = 1'b1;
              wr_val = 1'b1;
              set_valid = 1'b1;
              occ_nxt = occ_r + 9'd1;
              res_nxt.status = lpkv_pkg::ST_OK;
            end
          end
          state_nxt = B_DONE;
        end else if (hit) begin
          if (c_r.kind == lpkv_pkg::KIND_PUT) begin
            wr_val = 1'b1;
          end else begin
            res_nxt.found_value = rd_val;
          end
          res_nxt.status = lpkv_pkg::ST_OK;
          state_nxt = B_DONE;
        end else if (n_r == CW'(CAPACITY - 1)) begin
          if (c_r.kind == lpkv_pkg::KIND_PUT) res_nxt.status = lpkv_pkg::ST_FULL;
          state_nxt = B_DONE;
        end else begin
          n_nxt     = n_r + CW'(1);
          slot_nxt  = (slot_r == SW'(CAPACITY - 1)) ? '0 : slot_r + SW'(1);
          state_nxt = B_READ;
        end
      end
      B_DONE: begin
        res_nxt.entry_count = occ_r;
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (out_ready) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      occ_r   <= '0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (set_valid) valid_r[slot_r] <= 1'b1;
    end
    c_r    <= c_nxt;
    rem_r  <= rem_nxt;
    dig_r  <= dig_nxt;
    slot_r <= slot_nxt;
    n_r    <= n_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/linear_probe_key_value_table.sv
// Linear probing key/value table. A front stage takes a transaction, masks the
// key to its length and hashes it one byte per cycle; it takes the next
// transaction only after it has handed on the command. It hands the command
// through a two-entry queue to the back stage, which reduces the hash modulo
// CAPACITY four hash bits at a time and probes the slot memories slot by slot,
// reading and then checking each. A put or get probes from the home slot until
// it meets the key or an empty slot, or has probed every slot; a key-at-index
// walks the slots from zero. The back takes a new command only once its result
// is taken. Results leave through a held register.
// depends on lpkv_pkg, lpkv_front, lpkv_fifo, lpkv_back
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_key_value_table #(
  parameter int CAPACITY  = lpkv_pkg::CAPACITY_DEF,
  parameter int KEY_BYTES = lpkv_pkg::KEY_BYTES_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  lpkv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output lpkv_pkg::out_item_t out_data,
  input  wire                 cfg_we,
  input  wire [8:0]           cfg_wdata
);

  logic [8:0]     max_entries_r;
  logic           f_valid, f_ready, q_valid, q_ready;
  lpkv_pkg::cmd_t f_cmd, q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) max_entries_r <= lpkv_pkg::MAXE_RESET;
    else if (cfg_we) max_entries_r <= cfg_wdata;
  end

  lpkv_front #(.KEY_BYTES(KEY_BYTES)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  lpkv_fifo u_fifo (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  lpkv_back #(.CAPACITY(CAPACITY)) u_back (
    .clk, .rst_n, .max_entries(max_entries_r),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_valid, .out_ready, .out_data
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_count <= 9'(CAPACITY))
    else $error("entry count above capacity");
  a_get_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != lpkv_pkg::ST_OK |-> out_data.found_value == 0)
    else $error("value on failed result");
`endif

endmodule
`default_nettype wire

### verif/testbench.sv
// testbench: self-checking bench for linear_probe_key_value_table
// depends on lpkv_pkg and the table rtl; holds its own table predictor
`timescale 1ns / 1ps
module testbench;

  localparam int SLOTS = 256;
  localparam int NKEYB = 15;

  class table_scoreboard;
    bit [8:0]     limit;
    bit           used [SLOTS];
    bit [63:0]    klo [SLOTS];
    bit [55:0]    khi [SLOTS];
    bit [3:0]     klen [SLOTS];
    bit [31:0]    val [SLOTS];
    int           count;
    lpkv_pkg::out_item_t pending [$];
    int           errors;
    int           n_checked;
    int           n_full, n_miss, n_hit;

    function void clear();
      limit = lpkv_pkg::MAXE_RESET;
      foreach (used[i]) used[i] = 0;
      count = 0;
    endfunction

    function int home(bit [63:0] lo, bit [55:0] hi, int len);
      bit [31:0] h;
      bit [7:0] b;
      h = 0;
      for (int i = 0; i < len; i++) begin
        b = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
        h = h * 33 + b;
      end
      return h % SLOTS;
    endfunction

    function void note_input(lpkv_pkg::in_item_t it);
      lpkv_pkg::out_item_t r;
      int len, s, cnt;
      bit [63:0] lo;
      bit [55:0] hi;
      bit done;
      r = '0;
      r.status = lpkv_pkg::ST_NOTFOUND;
      len = (it.key_len > NKEYB) ? NKEYB : it.key_len;
      lo = 0;
      hi = 0;
      for (int i = 0; i < len; i++) begin
        if (i < 8) lo[8*i +: 8] = it.key_lo[8*i +: 8];
        else hi[8*(i-8) +: 8] = it.key_hi[8*(i-8) +: 8];
      end
      if (it.kind == lpkv_pkg::KIND_PUT) begin
        done = 0;
        s = home(lo, hi, len);
        for (int n = 0; n < SLOTS && !done; n++) begin
          if (!used[s]) begin
            if (count >= limit) r.status = lpkv_pkg::ST_FULL;
            else begin
              used[s] = 1; klo[s] = lo; khi[s] = hi; klen[s] = 4'(len);
              val[s] = it.put_value; count++; r.status = lpkv_pkg::ST_OK;
            end
            done = 1;
          end else if (klen[s] == len && klo[s] == lo && khi[s] == hi) begin
            val[s] = it.put_value; r.status = lpkv_pkg::ST_OK; done = 1;
          end else s = (s + 1) % SLOTS;
        end
        if (!done) r.status = lpkv_pkg::ST_FULL;
      end else if (it.kind == lpkv_pkg::KIND_GET) begin
        s = home(lo, hi, len);
        for (int n = 0; n < SLOTS; n++) begin
          if (!used[s]) break;
          if (klen[s] == len && klo[s] == lo && khi[s] == hi) begin
            r.found_value = val[s]; r.status = lpkv_pkg::ST_OK; break;
          end
          s = (s + 1) % SLOTS;
        end
      end else if (it.kind == lpkv_pkg::KIND_RANK) begin
        cnt = 0;
        for (s = 0; s < SLOTS; s++) begin
          if (used[s]) begin
            if (cnt == it.slot_rank) begin
              r.out_key_lo = klo[s]; r.out_key_hi = khi[s];
              r.out_key_len = klen[s]; r.status = lpkv_pkg::ST_OK; break;
            end
            cnt++;
          end
        end
      end
      r.entry_count = count[8:0];
      if (r.status == lpkv_pkg::ST_FULL) n_full++;
      else if (r.status == lpkv_pkg::ST_NOTFOUND) n_miss++;
      else n_hit++;
      pending.push_back(r);
    endfunction

    function void check_result(lpkv_pkg::out_item_t got);
      lpkv_pkg::out_item_t e;
      n_checked++;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.found_value !== e.found_value) begin
        $error("found_value exp %0d got %0d", e.found_value, got.found_value); errors++;
      end
      if (got.out_key_lo !== e.out_key_lo) begin
        $error("out_key_lo exp %h got %h", e.out_key_lo, got.out_key_lo); errors++;
      end
      if (got.out_key_hi !== e.out_key_hi) begin
        $error("out_key_hi exp %h got %h", e.out_key_hi, got.out_key_hi); errors++;
      end
      if (got.out_key_len !== e.out_key_len) begin
        $error("out_key_len exp %0d got %0d", e.out_key_len, got.out_key_len); errors++;
      end
      if (got.entry_count !== e.entry_count) begin
        $error("entry_count exp %0d got %0d", e.entry_count, got.entry_count); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  lpkv_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  lpkv_pkg::out_item_t out_data;
  logic cfg_we = 0;
  logic [8:0] cfg_wdata = '0;

  always #1 clk = ~clk;

  linear_probe_key_value_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  table_scoreboard sb = new();
  int idle_cycles;
  bit hold_off;
  bit stim_done;
  int n_sent;

  // key pool keeps gets and updates hitting stored keys
  bit [63:0] pool_lo [64];
  bit [55:0] pool_hi [64];
  bit [3:0]  pool_len [64];

  // result side: random stalls plus two long hold-offs
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    int w;
    @(posedge clk);
    while (1) begin
      w = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (hold_off) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(lpkv_pkg::in_item_t it, bit no_gap);
    int w;
    w = no_gap ? 0 : $urandom_range(0, 6);
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    n_sent++;
  endtask

  task automatic drain_and_set(bit [8:0] lim);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wdata <= lim;
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    sb.limit = lim;
  endtask

  function automatic lpkv_pkg::in_item_t rand_item(int put_pct);
    lpkv_pkg::in_item_t it;
    int p, r;
    it.key_lo = {$urandom, $urandom};
    it.key_hi = 56'({$urandom, $urandom});
    it.key_len = 4'($urandom_range(0, 15));
    it.put_value = $urandom;
    it.slot_rank = 8'(($urandom_range(0, 1)) ? $urandom_range(0, 40) : $urandom);
    r = $urandom_range(0, 99);
    if (r < put_pct) it.kind = lpkv_pkg::KIND_PUT;
    else if (r < put_pct + 30) it.kind = lpkv_pkg::KIND_GET;
    else if (r < 97) it.kind = lpkv_pkg::KIND_RANK;
    else it.kind = lpkv_pkg::KIND_UNUSED;
    if ($urandom_range(0, 3) != 0) begin
      p = $urandom_range(0, 63);
      it.key_lo = pool_lo[p] | ({$urandom, $urandom} & ~((64'd1 << (8 * pool_len[p])) - 1));
      it.key_hi = pool_hi[p];
      it.key_len = pool_len[p];
      // short keys reach upper key bits anyway, since they are ignored
      if (pool_len[p] <= 8) it.key_hi = 56'({$urandom, $urandom});
    end
    return it;
  endfunction

  initial begin
    lpkv_pkg::in_item_t it;
    bit [8:0] lims [6] = '{9'd4, 9'd1, 9'd0, 9'd256, 9'd511, 9'd40};
    int nph;
    sb.clear();
    foreach (pool_lo[i]) begin
      pool_len[i] = 4'($urandom_range(0, 15));
      pool_lo[i] = {$urandom, $urandom};
      pool_hi[i] = 56'({$urandom, $urandom});
      if (pool_len[i] < 8) pool_lo[i] &= (64'd1 << (8 * pool_len[i])) - 1;
      if (pool_len[i] <= 8) pool_hi[i] = 0;
      else pool_hi[i] &= (56'd1 << (8 * (pool_len[i] - 8))) - 1;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extreme fields, every kind, update, miss, zero-length key
    it = '0;
    send_item(it, 0);                              // put empty key
    it.put_value = 32'h7fffffff; send_item(it, 0); // update same key
    it.kind = lpkv_pkg::KIND_GET; send_item(it, 0);
    it = '0; it.kind = lpkv_pkg::KIND_PUT; it.key_lo = '1; it.key_hi = '1; it.key_len = 15;
    it.put_value = 32'h80000000; send_item(it, 0);
    it.kind = lpkv_pkg::KIND_GET; it.key_lo = '1; send_item(it, 0);
    it.key_len = 4'd14; send_item(it, 0);          // different length, miss
    it = '0; it.kind = lpkv_pkg::KIND_PUT; it.key_lo = 64'h00; it.key_len = 1;
    it.put_value = -5; send_item(it, 0);          // zero byte in key
    it.kind = lpkv_pkg::KIND_RANK; it.slot_rank = 0; send_item(it, 0);
    it.slot_rank = 2; send_item(it, 0);
    it.slot_rank = 3; send_item(it, 0);
    it.slot_rank = 8'hff; send_item(it, 0);
    it.kind = lpkv_pkg::KIND_UNUSED; send_item(it, 0);
    it.kind = lpkv_pkg::KIND_GET; it.key_lo = 64'h1234; it.key_len = 2; send_item(it, 0);

    // phases through limits; small limits exercise refused inserts
    for (nph = 0; nph < 7; nph++) begin
      if (nph > 0) drain_and_set(lims[nph - 1]);
      repeat (nph == 3 || nph == 4 ? 260 : 110) begin
        it = rand_item(nph == 3 || nph == 4 ? 65 : 45);
        send_item(it, $urandom_range(0, 4) == 0);
        if (n_sent == 200) hold_off = 1;
      end
    end

    // long back-to-back stretch while the receiver holds off
    hold_off = 1;
    repeat (30) send_item(rand_item(40), 1);
    in_valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d transactions, checked %0d results", n_sent, sb.n_checked);
    $display("ok %0d, not found %0d, full %0d", sb.n_hit, sb.n_miss, sb.n_full);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

### sim.f
hw/rtl/lpkv_pkg.sv
hw/rtl/lpkv_front.sv
hw/rtl/lpkv_fifo.sv
hw/rtl/lpkv_back.sv
hw/rtl/linear_probe_key_value_table.sv
verif/testbench.sv
